>>> sv/task_rendezvous_message_engine_unit_macros.svh
// ---------------------------------------------------------------------------
// Rendezvous message engine assertion macros
// Shorthand for clocked implication checks on clk, disabled during rst.
// ---------------------------------------------------------------------------
`ifndef TASK_RENDEZVOUS_MESSAGE_ENGINE_UNIT_MACROS_SVH
`define TASK_RENDEZVOUS_MESSAGE_ENGINE_UNIT_MACROS_SVH

// same-cycle implication
`define TRME_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TRME_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/trme_pkg.sv
// ---------------------------------------------------------------------------
// trme_pkg
// Shared types and constants of the rendezvous message engine.
// ---------------------------------------------------------------------------
`default_nettype none

package trme_pkg;

  localparam int MAX_TASKS = 16;
  localparam int ID_W      = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int TAG_W     = 16;
  localparam int VAL_W     = 16;

  typedef logic [ID_W-1:0]  task_id_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [2:0] {
    FN_SEND   = 3'd0,
    FN_RECV   = 3'd1,
    FN_REPLY  = 3'd2,
    FN_CREATE = 3'd3,
    FN_TERM   = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    TS_DEAD   = 3'd0,
    TS_READY  = 3'd1,
    TS_WSEND  = 3'd2,
    TS_WRECV  = 3'd3,
    TS_WREPLY = 3'd4
  } task_state_t;

  typedef enum logic [2:0] {
    RS_BLOCKED = 3'd0,
    RS_MEET    = 3'd1,
    RS_BAD     = 3'd2,
    RS_IGNORED = 3'd3,
    RS_CREATED = 3'd4,
    RS_FULL    = 3'd5,
    RS_TERM    = 3'd6
  } result_t;

  typedef struct packed {
    task_state_t      state;
    task_id_t         peer;
    logic [TAG_W-1:0] tag;
    logic [VAL_W-1:0] msg;
  } entry_t;

  // one access to the task table per cycle: one write, one read
  typedef struct packed {
    logic     we;
    task_id_t waddr;
    entry_t   wdata;
    logic     set_live;
    logic     clr_live;
    task_id_t raddr;
  } tbl_req_t;

endpackage

`default_nettype wire

>>> sv/trme_table.sv
// ---------------------------------------------------------------------------
// trme_table
// Task table: one synchronous memory of task entries plus a live bit per
// slot. A slot that is not live reads back as a dead, cleared entry.
// ---------------------------------------------------------------------------
`default_nettype none

module trme_table (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire trme_pkg::tbl_req_t                  req,
  output trme_pkg::entry_t                         rd_entry,
  output logic [trme_pkg::MAX_TASKS-1:0]           live
);

  trme_pkg::entry_t mem [trme_pkg::MAX_TASKS];
  trme_pkg::entry_t rd_q;
  logic             rd_live;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_q <= mem[req.raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live    <= '0;
      rd_live <= 1'b0;
    end else begin
      if (req.set_live) begin
        live[req.waddr] <= 1'b1;
      end
      if (req.clr_live) begin
        live[req.waddr] <= 1'b0;
      end
      rd_live <= live[req.raddr];
    end
  end

  always_comb begin
    if (rd_live) begin
      rd_entry = rd_q;
    end else begin
      rd_entry       = '0;
      rd_entry.state = trme_pkg::TS_DEAD;
    end
  end

endmodule

`default_nettype wire

>>> sv/task_rendezvous_message_engine_unit.sv
// ---------------------------------------------------------------------------
// task_rendezvous_message_engine_unit
// Send / receive / reply rendezvous kernel over a table of task slots.
//
//   channel   handshake           payload
//   request   start & !busy       func caller target_task tag_bits msg_value
//   result    done (one cycle)    status partner_id caller_state
//                                 deliver_valid deliver_to deliver_value
//
// One request at a time; busy is high from the cycle after accept through the
// done cycle, so the next request can be accepted in the cycle after done.
// Create, terminate and unknown codes go S_OP, S_FIN, S_OUT; send, reply and
// receive first check the table in S_CHK, and the receive scan in S_SCAN reads one
// table entry per cycle through the single read port of the task table.
// rst is synchronous; all slots read as dead after reset, no clearing pass.
// The result strobe cannot be held off by the receiver.
// ---------------------------------------------------------------------------
`default_nettype none

`include "task_rendezvous_message_engine_unit_macros.svh"

module task_rendezvous_message_engine_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [2:0]                    func,
  input  wire logic [3:0]                    caller,
  input  wire logic [3:0]                    target_task,
  input  wire logic [trme_pkg::TAG_W-1:0]    tag_bits,
  input  wire logic [trme_pkg::VAL_W-1:0]    msg_value,
  output logic                               done,
  output logic [2:0]                         status,
  output logic [3:0]                         partner_id,
  output logic [2:0]                         caller_state,
  output logic                               deliver_valid,
  output logic [3:0]                         deliver_to,
  output logic [trme_pkg::VAL_W-1:0]         deliver_value
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_OP   = 8'b0000_0010,
    S_CHK  = 8'b0000_0100,
    S_CHK2 = 8'b0000_1000,
    S_SCAN = 8'b0001_0000,
    S_WR2  = 8'b0010_0000,
    S_FIN  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } fsm_t;

  fsm_t                          state;
  trme_pkg::func_t               func_r;
  trme_pkg::task_id_t            caller_r;
  trme_pkg::task_id_t            target_r;
  logic [trme_pkg::TAG_W-1:0]    tag_r;
  logic [trme_pkg::VAL_W-1:0]    val_r;
  trme_pkg::result_t             st_r;
  trme_pkg::task_id_t            partner_r;
  logic                          dv_r;
  trme_pkg::task_id_t            dto_r;
  logic [trme_pkg::VAL_W-1:0]    dval_r;
  trme_pkg::entry_t              keep_r;
  trme_pkg::task_id_t            wr2_addr;
  trme_pkg::entry_t              wr2_entry;
  trme_pkg::cnt_t                scan_cnt;

  trme_pkg::tbl_req_t            tbl_req;
  trme_pkg::entry_t              rd;
  logic [trme_pkg::MAX_TASKS-1:0] live;

  logic                          tag_hit;
  logic                          send_meet;
  logic                          scan_hit;
  logic                          scan_end;
  logic                          reply_hit;
  trme_pkg::task_id_t            scan_idx;
  trme_pkg::task_id_t            free_idx;
  logic                          free_found;

  trme_table u_table (
    .clk      (clk),
    .rst      (rst),
    .req      (tbl_req),
    .rd_entry (rd),
    .live     (live)
  );

  assign tag_hit   = (rd.tag & tag_r) != '0;
  // a self-send leaves the caller in wait send, so it never meets
  assign send_meet = (rd.state == trme_pkg::TS_WRECV) && tag_hit && (target_r != caller_r);
  assign scan_idx  = trme_pkg::task_id_t'(scan_cnt - 1'b1);
  // scan_cnt is one ahead of the entry whose data is on rd
  assign scan_hit  = (scan_cnt != '0) && (rd.state == trme_pkg::TS_WSEND) &&
                     (rd.peer == caller_r) && tag_hit && (scan_idx != caller_r);
  assign scan_end  = scan_cnt == trme_pkg::cnt_t'(trme_pkg::MAX_TASKS);
  assign reply_hit = rd.state == trme_pkg::TS_WREPLY;

  // lowest-numbered dead slot
  always_comb begin
    free_idx   = '0;
    free_found = ~&live;
    for (int i = trme_pkg::MAX_TASKS - 1; i >= 0; i--) begin
      if (!live[i]) begin
        free_idx = trme_pkg::task_id_t'(i);
      end
    end
  end

  always_comb begin
    tbl_req       = '0;
    tbl_req.raddr = caller_r;
    unique case (state)
      S_OP: begin
        unique case (func_r)
          trme_pkg::FN_SEND: begin
            tbl_req.raddr = target_r;
          end
          trme_pkg::FN_CREATE: begin
            if (free_found) begin
              tbl_req.we             = 1'b1;
              tbl_req.set_live       = 1'b1;
              tbl_req.waddr          = free_idx;
              tbl_req.wdata.state    = trme_pkg::TS_READY;
              tbl_req.wdata.msg      = val_r;
            end
          end
          trme_pkg::FN_TERM: begin
            tbl_req.clr_live = 1'b1;
            tbl_req.waddr    = caller_r;
          end
          default: begin
            tbl_req.raddr = caller_r;
          end
        endcase
      end
      S_CHK: begin
        unique case (func_r)
          trme_pkg::FN_SEND: begin
            if (rd.state != trme_pkg::TS_DEAD) begin
              tbl_req.we          = 1'b1;
              tbl_req.set_live    = 1'b1;
              tbl_req.waddr       = caller_r;
              tbl_req.wdata.state = send_meet ? trme_pkg::TS_WREPLY : trme_pkg::TS_WSEND;
              tbl_req.wdata.peer  = target_r;
              tbl_req.wdata.tag   = tag_r;
              tbl_req.wdata.msg   = val_r;
            end
          end
          trme_pkg::FN_RECV: begin
            tbl_req.raddr = '0;
          end
          trme_pkg::FN_REPLY: begin
            tbl_req.raddr = rd.peer;
          end
          default: begin
            tbl_req.raddr = caller_r;
          end
        endcase
      end
      S_CHK2: begin
        if (reply_hit) begin
          tbl_req.we          = 1'b1;
          tbl_req.waddr       = wr2_addr;
          tbl_req.wdata       = rd;
          tbl_req.wdata.state = trme_pkg::TS_READY;
        end
      end
      S_SCAN: begin
        tbl_req.raddr = scan_cnt[trme_pkg::ID_W-1:0];
        if (scan_hit) begin
          tbl_req.we          = 1'b1;
          tbl_req.waddr       = scan_idx;
          tbl_req.wdata       = rd;
          tbl_req.wdata.state = trme_pkg::TS_WREPLY;
        end else if (scan_end) begin
          tbl_req.we          = 1'b1;
          tbl_req.set_live    = 1'b1;
          tbl_req.waddr       = caller_r;
          tbl_req.wdata.state = trme_pkg::TS_WRECV;
          tbl_req.wdata.tag   = tag_r;
          tbl_req.wdata.msg   = keep_r.msg;
        end
      end
      S_WR2: begin
        tbl_req.we       = 1'b1;
        tbl_req.set_live = 1'b1;
        tbl_req.waddr    = wr2_addr;
        tbl_req.wdata    = wr2_entry;
      end
      S_FIN: begin
        tbl_req.raddr = caller_r;
      end
      default: begin
        tbl_req.raddr = caller_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      scan_cnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            func_r    <= trme_pkg::func_t'(func);
            caller_r  <= caller;
            target_r  <= target_task;
            tag_r     <= tag_bits;
            val_r     <= msg_value;
            st_r      <= trme_pkg::RS_BAD;
            partner_r <= '0;
            dv_r      <= 1'b0;
            dto_r     <= '0;
            dval_r    <= '0;
            state     <= S_OP;
          end
        end
        S_OP: begin
          unique case (func_r) inside
            trme_pkg::FN_SEND, trme_pkg::FN_RECV, trme_pkg::FN_REPLY: begin
              state <= S_CHK;
            end
            trme_pkg::FN_CREATE: begin
              st_r      <= free_found ? trme_pkg::RS_CREATED : trme_pkg::RS_FULL;
              partner_r <= free_found ? free_idx : '0;
              state     <= S_FIN;
            end
            trme_pkg::FN_TERM: begin
              st_r  <= trme_pkg::RS_TERM;
              state <= S_FIN;
            end
            default: begin
              state <= S_FIN;
            end
          endcase
        end
        S_CHK: begin
          unique case (func_r)
            trme_pkg::FN_SEND: begin
              if (send_meet) begin
                st_r      <= trme_pkg::RS_MEET;
                partner_r <= target_r;
                dv_r      <= 1'b1;
                dto_r     <= target_r;
                dval_r    <= val_r;
                wr2_addr  <= target_r;
                wr2_entry <= {trme_pkg::TS_READY, caller_r, rd.tag, rd.msg};
                state     <= S_WR2;
              end else if (rd.state != trme_pkg::TS_DEAD) begin
                st_r  <= trme_pkg::RS_BLOCKED;
                state <= S_FIN;
              end else begin
                state <= S_FIN;
              end
            end
            trme_pkg::FN_RECV: begin
              keep_r   <= rd;
              scan_cnt <= trme_pkg::cnt_t'(1);
              state    <= S_SCAN;
            end
            trme_pkg::FN_REPLY: begin
              wr2_addr <= rd.peer;
              state    <= S_CHK2;
            end
            default: begin
              state <= S_FIN;
            end
          endcase
        end
        S_CHK2: begin
          if (reply_hit) begin
            st_r      <= trme_pkg::RS_MEET;
            partner_r <= wr2_addr;
            dv_r      <= 1'b1;
            dto_r     <= wr2_addr;
            dval_r    <= val_r;
          end else begin
            st_r <= trme_pkg::RS_IGNORED;
          end
          state <= S_FIN;
        end
        S_SCAN: begin
          if (scan_hit) begin
            st_r      <= trme_pkg::RS_MEET;
            partner_r <= scan_idx;
            dv_r      <= 1'b1;
            dto_r     <= caller_r;
            dval_r    <= rd.msg;
            wr2_addr  <= caller_r;
            wr2_entry <= {trme_pkg::TS_READY, scan_idx, tag_r, keep_r.msg};
            state     <= S_WR2;
          end else if (scan_end) begin
            st_r  <= trme_pkg::RS_BLOCKED;
            state <= S_FIN;
          end else begin
            scan_cnt <= scan_cnt + 1'b1;
          end
        end
        S_WR2: begin
          state <= S_FIN;
        end
        S_FIN: begin
          state <= S_OUT;
        end
        S_OUT: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy          = state != S_IDLE;
  assign done          = state == S_OUT;
  assign status        = st_r;
  assign partner_id    = partner_r;
  assign caller_state  = rd.state;   // caller entry read back in S_FIN
  assign deliver_valid = dv_r;
  assign deliver_to    = dto_r;
  assign deliver_value = dval_r;

  `TRME_ASSERT_NXT(a_accept_busy, start && !busy, busy, "request accepted but engine not busy")
  `TRME_ASSERT_NXT(a_done_idle, done, !busy, "engine still busy after result strobe")
  `TRME_ASSERT_IMP(a_deliver_meet, done && deliver_valid, status == trme_pkg::RS_MEET, "delivery without rendezvous")
  `TRME_ASSERT_IMP(a_idle_no_write, tbl_req.we || tbl_req.clr_live, busy, "table written while idle")
  `TRME_ASSERT_IMP(a_scan_range, state == S_SCAN, (scan_cnt != '0) && (scan_cnt <= trme_pkg::cnt_t'(trme_pkg::MAX_TASKS)), "scan index out of range")

endmodule

`default_nettype wire

>>> verif/testbench.sv
// ---------------------------------------------------------------------------
// Rendezvous message engine testbench
// Drives kernel requests (create, terminate, send, receive, reply and the
// undefined codes) through the start/busy port and checks each done strobe
// against a task-table predictor kept in step with every accepted request.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam int MAX_TASKS    = trme_pkg::MAX_TASKS;
  localparam int TAG_W        = trme_pkg::TAG_W;
  localparam int VAL_W        = trme_pkg::VAL_W;
  localparam int NUM_REQUESTS = 1800;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 30;
  localparam int MAX_REPORTS  = 10;

  // first func code the block does not define
  localparam logic [2:0] FN_UNKNOWN_LO = 3'd5;

  typedef struct {
    logic [2:0]       fn;
    logic [3:0]       who;
    logic [3:0]       dst;
    logic [TAG_W-1:0] tag;
    logic [VAL_W-1:0] val;
    int               gap;
  } kreq_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [3:0]       partner;
    logic [2:0]       cstate;
    logic             dv;
    logic [3:0]       dto;
    logic [VAL_W-1:0] dval;
  } kresp_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic [2:0]       func = '0;
  logic [3:0]       caller = '0;
  logic [3:0]       target_task = '0;
  logic [TAG_W-1:0] tag_bits = '0;
  logic [VAL_W-1:0] msg_value = '0;
  logic             busy;
  logic             done;
  logic [2:0]       status;
  logic [3:0]       partner_id;
  logic [2:0]       caller_state;
  logic             deliver_valid;
  logic [3:0]       deliver_to;
  logic [VAL_W-1:0] deliver_value;

  task_rendezvous_message_engine_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .func          (func),
    .caller        (caller),
    .target_task   (target_task),
    .tag_bits      (tag_bits),
    .msg_value     (msg_value),
    .done          (done),
    .status        (status),
    .partner_id    (partner_id),
    .caller_state  (caller_state),
    .deliver_valid (deliver_valid),
    .deliver_to    (deliver_to),
    .deliver_value (deliver_value)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predicted task table
  trme_pkg::task_state_t slot_state [MAX_TASKS];
  trme_pkg::task_id_t    slot_peer  [MAX_TASKS];
  logic [TAG_W-1:0]      slot_tag   [MAX_TASKS];
  logic [VAL_W-1:0]      slot_msg   [MAX_TASKS];

  kreq_t  request_q[$];
  kresp_t expected_outcomes[$];
  int     issued_cnt = 0;
  int     accepted_cnt = 0;
  int     mismatch_cnt = 0;
  int     cycle_cnt = 0;
  int     outcome_hits [8];
  bit     calm = 1'b0;

  initial begin
    for (int i = 0; i < MAX_TASKS; i++) begin
      slot_state[i] = trme_pkg::TS_DEAD;
      slot_peer[i]  = '0;
      slot_tag[i]   = '0;
      slot_msg[i]   = '0;
    end
    for (int i = 0; i < 8; i++) outcome_hits[i] = 0;
  end

  function automatic kresp_t apply_request(kreq_t rq);
    kresp_t rs;
    bit     who_ok;
    int     p;
    rs = '0;
    rs.status = trme_pkg::RS_BAD;
    who_ok = int'(rq.who) < MAX_TASKS;
    case (rq.fn)
      trme_pkg::FN_SEND: begin
        if (who_ok && int'(rq.dst) < MAX_TASKS && slot_state[rq.dst] != trme_pkg::TS_DEAD) begin
          slot_peer[rq.who]  = rq.dst;
          slot_tag[rq.who]   = rq.tag;
          slot_msg[rq.who]   = rq.val;
          slot_state[rq.who] = trme_pkg::TS_WSEND;
          rs.status = trme_pkg::RS_BLOCKED;
          // a send to oneself finds itself in wait send and never meets
          if (slot_state[rq.dst] == trme_pkg::TS_WRECV &&
              (slot_tag[rq.dst] & rq.tag) != '0) begin
            slot_peer[rq.dst]  = rq.who;
            slot_state[rq.dst] = trme_pkg::TS_READY;
            slot_state[rq.who] = trme_pkg::TS_WREPLY;
            rs.status  = trme_pkg::RS_MEET;
            rs.partner = rq.dst;
            rs.dv      = 1'b1;
            rs.dto     = rq.dst;
            rs.dval    = rq.val;
          end
        end
      end
      trme_pkg::FN_RECV: begin
        if (who_ok) begin
          slot_peer[rq.who]  = '0;
          slot_tag[rq.who]   = rq.tag;
          slot_state[rq.who] = trme_pkg::TS_WRECV;
          rs.status = trme_pkg::RS_BLOCKED;
          for (int x = 0; x < MAX_TASKS; x++) begin
            if (slot_state[x] == trme_pkg::TS_WSEND && slot_peer[x] == rq.who &&
                (slot_tag[x] & rq.tag) != '0) begin
              slot_peer[rq.who]  = trme_pkg::task_id_t'(x);
              slot_state[x]      = trme_pkg::TS_WREPLY;
              slot_state[rq.who] = trme_pkg::TS_READY;
              rs.status  = trme_pkg::RS_MEET;
              rs.partner = 4'(x);
              rs.dv      = 1'b1;
              rs.dto     = rq.who;
              rs.dval    = slot_msg[x];
              break;
            end
          end
        end
      end
      trme_pkg::FN_REPLY: begin
        if (who_ok) begin
          p = int'(slot_peer[rq.who]);
          rs.status = trme_pkg::RS_IGNORED;
          // partner is not required to be waiting on this caller
          if (p < MAX_TASKS && slot_state[p] == trme_pkg::TS_WREPLY) begin
            slot_state[p] = trme_pkg::TS_READY;
            rs.status  = trme_pkg::RS_MEET;
            rs.partner = 4'(p);
            rs.dv      = 1'b1;
            rs.dto     = 4'(p);
            rs.dval    = rq.val;
          end
        end
      end
      trme_pkg::FN_CREATE: begin
        rs.status = trme_pkg::RS_FULL;
        for (int x = 0; x < MAX_TASKS; x++) begin
          if (slot_state[x] == trme_pkg::TS_DEAD) begin
            slot_state[x] = trme_pkg::TS_READY;
            slot_peer[x]  = '0;
            slot_tag[x]   = '0;
            rs.status  = trme_pkg::RS_CREATED;
            rs.partner = 4'(x);
            break;
          end
        end
      end
      trme_pkg::FN_TERM: begin
        if (who_ok) begin
          slot_state[rq.who] = trme_pkg::TS_DEAD;
          slot_peer[rq.who]  = '0;
          slot_tag[rq.who]   = '0;
          rs.status = trme_pkg::RS_TERM;
        end
      end
      default: ;
    endcase
    rs.cstate = who_ok ? slot_state[rq.who] : trme_pkg::TS_DEAD;
    return rs;
  endfunction

  function automatic void queue_request(logic [2:0] fn, logic [3:0] who, logic [3:0] dst,
                                        logic [TAG_W-1:0] tag, logic [VAL_W-1:0] val);
    kreq_t rq;
    rq.fn  = fn;
    rq.who = who;
    rq.dst = dst;
    rq.tag = tag;
    rq.val = val;
    rq.gap = calm ? 0 : $urandom_range(0, 19);
    request_q.push_back(rq);
  endfunction

  // one send/receive/reply exchange with random content, sometimes after a create
  function automatic void queue_exchange();
    logic [3:0]       a;
    logic [3:0]       b;
    logic [TAG_W-1:0] tag;
    logic [TAG_W-1:0] mask;
    a   = 4'($urandom_range(0, 15));
    b   = 4'($urandom_range(0, 15));
    tag = TAG_W'($urandom_range(1, 65535));
    mask = TAG_W'($urandom_range(0, 65535));
    if ($urandom_range(0, 9) != 0) mask = mask | (tag & (~tag + 1'b1));
    if ($urandom_range(0, 3) == 0) queue_request(trme_pkg::FN_CREATE, a, b, '0, '0);
    if ($urandom_range(0, 1) == 0) begin
      queue_request(trme_pkg::FN_SEND, a, b, tag, VAL_W'($urandom));
      queue_request(trme_pkg::FN_RECV, b, a, mask, VAL_W'($urandom));
    end else begin
      queue_request(trme_pkg::FN_RECV, b, a, mask, VAL_W'($urandom));
      queue_request(trme_pkg::FN_SEND, a, b, tag, VAL_W'($urandom));
    end
    if ($urandom_range(0, 4) != 0)
      queue_request(trme_pkg::FN_REPLY, b, a, TAG_W'($urandom), VAL_W'($urandom));
    else
      queue_request(trme_pkg::FN_REPLY, 4'($urandom), a, TAG_W'($urandom),
                    VAL_W'($urandom));
  endfunction

  // driver: inputs change on the falling edge
  int gap_left = 0;
  always @(negedge clk) begin
    kreq_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else if (start && accepted_cnt != issued_cnt) begin
      // request still waiting for !busy
    end else if (gap_left > 0) begin
      start    <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (request_q.size() > 0) begin
      nxt = request_q.pop_front();
      func        <= nxt.fn;
      caller      <= nxt.who;
      target_task <= nxt.dst;
      tag_bits    <= nxt.tag;
      msg_value   <= nxt.val;
      start       <= 1'b1;
      gap_left    <= nxt.gap;
      issued_cnt  <= issued_cnt + 1;
    end else begin
      start <= 1'b0;
    end
  end

  task automatic note_mismatch(string what, kresp_t want, kresp_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS)
      $display("[%0d] %s: exp st=%0d pt=%0d cs=%0d dv=%0d to=%0d val=%h, got st=%0d pt=%0d cs=%0d dv=%0d to=%0d val=%h",
               cycle_cnt, what, want.status, want.partner, want.cstate, want.dv,
               want.dto, want.dval, got.status, got.partner, got.cstate, got.dv,
               got.dto, got.dval);
  endtask

  // monitor: predict on accept, check on done
  always @(posedge clk) begin
    kreq_t  taken;
    kresp_t want;
    kresp_t got;
    if (!rst) begin
      if (start && !busy) begin
        taken.fn  = func;
        taken.who = caller;
        taken.dst = target_task;
        taken.tag = tag_bits;
        taken.val = msg_value;
        taken.gap = 0;
        want = apply_request(taken);
        expected_outcomes.push_back(want);
        outcome_hits[want.status]++;
        accepted_cnt <= accepted_cnt + 1;
      end
      if (done) begin
        got = {status, partner_id, caller_state, deliver_valid, deliver_to, deliver_value};
        if (expected_outcomes.size() == 0) begin
          note_mismatch("unexpected result", '0, got);
        end else begin
          want = expected_outcomes.pop_front();
          if (got.status !== want.status || got.partner !== want.partner ||
              got.cstate !== want.cstate || got.dv !== want.dv ||
              got.dto !== want.dto || got.dval !== want.dval)
            note_mismatch("result mismatch", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    // directed: empty table, unknown code, fill to full, one full rendezvous
    queue_request(trme_pkg::FN_REPLY, 4'd0, 4'd0, '0, '0);
    queue_request(trme_pkg::FN_SEND, 4'd0, 4'd1, '1, '1);
    queue_request(trme_pkg::FN_RECV, 4'd2, 4'd0, '1, '0);
    queue_request(FN_UNKNOWN_LO, 4'd15, 4'd15, '1, '1);
    for (int i = 0; i < MAX_TASKS; i++)
      queue_request(trme_pkg::FN_CREATE, 4'(i), 4'(i), '0, '0);
    queue_request(trme_pkg::FN_CREATE, 4'd15, 4'd0, '1, '1);
    queue_request(trme_pkg::FN_SEND, 4'd0, 4'd0, '1, '1);
    queue_request(trme_pkg::FN_RECV, 4'd15, 4'd0, '1, '0);
    queue_request(trme_pkg::FN_SEND, 4'd14, 4'd15, 16'h8000, '1);
    queue_request(trme_pkg::FN_REPLY, 4'd15, 4'd0, '0, '1);
    queue_request(trme_pkg::FN_TERM, 4'd15, 4'd0, '0, '0);

    while (request_q.size() < NUM_REQUESTS) begin
      int r;
      if ($urandom_range(0, 39) == 0) calm = ~calm;
      r = $urandom_range(0, 99);
      if (r < 55)
        queue_exchange();
      else if (r < 70)
        queue_request(trme_pkg::FN_CREATE, 4'($urandom), 4'($urandom), TAG_W'($urandom),
                      VAL_W'($urandom));
      else if (r < 78)
        queue_request(trme_pkg::FN_TERM, 4'($urandom), 4'($urandom), TAG_W'($urandom),
                      VAL_W'($urandom));
      else
        queue_request(3'($urandom_range(0, 7)), 4'($urandom), 4'($urandom),
                      TAG_W'($urandom), VAL_W'($urandom));
    end

    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (request_q.size() != 0 || accepted_cnt != issued_cnt || start)
      @(posedge clk);
    while (expected_outcomes.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests: %0d rendezvous, %0d blocked, %0d bad, %0d replies ignored",
             accepted_cnt, outcome_hits[trme_pkg::RS_MEET], outcome_hits[trme_pkg::RS_BLOCKED],
             outcome_hits[trme_pkg::RS_BAD], outcome_hits[trme_pkg::RS_IGNORED]);
    $display("%0d created, %0d with table full, %0d terminated; %0d mismatches",
             outcome_hits[trme_pkg::RS_CREATED], outcome_hits[trme_pkg::RS_FULL],
             outcome_hits[trme_pkg::RS_TERM], mismatch_cnt);
    if (mismatch_cnt == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
+incdir+sv
sv/trme_pkg.sv
sv/trme_table.sv
sv/task_rendezvous_message_engine_unit.sv
verif/testbench.sv
